// File: hdl/twma_pkg.sv
`timescale 1ns / 1ps

package twma_pkg;

    // Fixed field widths
    localparam int STAMP_BITS  = 64;
    localparam int WINDOW_BITS = 32;
    localparam int SUM_BITS    = 22;

    // Parameter defaults
    localparam int RING_DEPTH_DEFAULT = 64;
    localparam int DELTA_BITS_DEFAULT = 16;

    // Purge window after reset: 10 ms in nanoseconds
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd10_000_000;

    // Item kinds
    localparam logic ACT_FRAME  = 1'b0;
    localparam logic ACT_MOTION = 1'b1;

    typedef logic signed [SUM_BITS-1:0] sum_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PURGE,
        ST_MOTION,
        ST_EMIT
    } twma_state_t;

endpackage

// File: hdl/twma_if.sv
`timescale 1ns / 1ps

// Input item channel
interface twma_sample_if #(
    parameter int DELTA_BITS = twma_pkg::DELTA_BITS_DEFAULT
);
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic [twma_pkg::STAMP_BITS-1:0]       time_ns;
    logic signed [DELTA_BITS-1:0]          delta_x;
    logic signed [DELTA_BITS-1:0]          delta_y;
    logic                                  has_focus;

    modport source (output valid, action, time_ns, delta_x, delta_y, has_focus,
                    input ready);
    modport sink   (input valid, action, time_ns, delta_x, delta_y, has_focus,
                    output ready);
endinterface

// Result item channel
interface twma_report_if #(
    parameter int COUNT_BITS = $clog2(twma_pkg::RING_DEPTH_DEFAULT + 1)
);
    logic                    valid;
    logic                    ready;
    twma_pkg::sum_t          sum_x;
    twma_pkg::sum_t          sum_y;
    logic [COUNT_BITS-1:0]   entry_count;
    logic                    evicted_full;

    modport source (output valid, sum_x, sum_y, entry_count, evicted_full,
                    input ready);
    modport sink   (input valid, sum_x, sum_y, entry_count, evicted_full,
                    output ready);
endinterface

// Window register write channel
interface twma_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [twma_pkg::WINDOW_BITS-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/twma_ring_mem.sv
`timescale 1ns / 1ps

// One write port, one read port, registered read data (read-before-write)
module twma_ring_mem #(
    parameter int DEPTH = twma_pkg::RING_DEPTH_DEFAULT,
    parameter int WIDTH = twma_pkg::STAMP_BITS + 2 * twma_pkg::DELTA_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/twma_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: ring pointers, running sums, purge/evict/append, result register
module twma_ctrl #(
    parameter int RING_DEPTH = twma_pkg::RING_DEPTH_DEFAULT,
    parameter int DELTA_BITS = twma_pkg::DELTA_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [twma_pkg::WINDOW_BITS-1:0]    window,
    twma_sample_if.sink                         sample,
    twma_report_if.source                       report,
    // ring memory
    output logic                                mem_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0]       mem_wr_addr,
    output logic [twma_pkg::STAMP_BITS+2*DELTA_BITS-1:0] mem_wr_data,
    output logic [$clog2(RING_DEPTH)-1:0]       mem_rd_addr,
    input  logic [twma_pkg::STAMP_BITS+2*DELTA_BITS-1:0] mem_rd_data
);

    localparam int ADDR_BITS  = $clog2(RING_DEPTH);
    localparam int COUNT_BITS = $clog2(RING_DEPTH + 1);
    localparam int SLOT_BITS  = ADDR_BITS + 1;
    localparam int STAMP_W    = twma_pkg::STAMP_BITS;
    localparam int PAD_W      = twma_pkg::STAMP_BITS - twma_pkg::WINDOW_BITS;

    localparam logic [ADDR_BITS-1:0]  HEAD_LAST = ADDR_BITS'(RING_DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] LEN_FULL  = COUNT_BITS'(RING_DEPTH);
    localparam logic [SLOT_BITS-1:0]  SLOT_WRAP = SLOT_BITS'(RING_DEPTH);

    function automatic twma_pkg::sum_t to_sum(input logic signed [DELTA_BITS-1:0] d);
        return twma_pkg::sum_t'(d);
    endfunction

    twma_pkg::twma_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0]         head_reg, head_next;
    logic [COUNT_BITS-1:0]        len_reg, len_next;
    twma_pkg::sum_t               acc_x_reg, acc_x_next;
    twma_pkg::sum_t               acc_y_reg, acc_y_next;
    logic [STAMP_W-1:0]           cutoff_reg, cutoff_next;
    logic [STAMP_W-1:0]           stamp_reg, stamp_next;
    logic signed [DELTA_BITS-1:0] dx_reg, dx_next;
    logic signed [DELTA_BITS-1:0] dy_reg, dy_next;
    logic                         evict_reg, evict_next;

    logic                         rpt_valid_reg, rpt_valid_next;
    twma_pkg::sum_t               rpt_x_reg, rpt_x_next;
    twma_pkg::sum_t               rpt_y_reg, rpt_y_next;
    logic [COUNT_BITS-1:0]        rpt_count_reg, rpt_count_next;
    logic                         rpt_evict_reg, rpt_evict_next;

    // Head entry fields (memory always holds a read of the current head)
    logic [STAMP_W-1:0]           rd_stamp;
    logic signed [DELTA_BITS-1:0] rd_dx;
    logic signed [DELTA_BITS-1:0] rd_dy;
    logic [ADDR_BITS-1:0]         head_inc;
    logic                         full;
    logic [SLOT_BITS-1:0]         slot_sum;
    logic [SLOT_BITS-1:0]         slot_wrap;
    logic [STAMP_W-1:0]           window_ext;

    assign rd_stamp   = mem_rd_data[STAMP_W+2*DELTA_BITS-1 -: STAMP_W];
    assign rd_dy      = signed'(mem_rd_data[2*DELTA_BITS-1 -: DELTA_BITS]);
    assign rd_dx      = signed'(mem_rd_data[DELTA_BITS-1:0]);
    assign head_inc   = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
    assign full       = (len_reg == LEN_FULL);
    assign window_ext = {{PAD_W{1'b0}}, window};

    // Tail slot: head + length, wrapped once
    assign slot_sum  = SLOT_BITS'(head_reg) + SLOT_BITS'(len_reg);
    assign slot_wrap = (slot_sum >= SLOT_WRAP) ? slot_sum - SLOT_WRAP : slot_sum;

    // Memory ports: read follows the next head so data is fresh each cycle
    assign mem_rd_addr = head_next;
    assign mem_wr_addr = full ? head_reg : slot_wrap[ADDR_BITS-1:0];
    assign mem_wr_data = {stamp_reg, dy_reg, dx_reg};

    assign report.valid        = rpt_valid_reg;
    assign report.sum_x        = rpt_x_reg;
    assign report.sum_y        = rpt_y_reg;
    assign report.entry_count  = rpt_count_reg;
    assign report.evicted_full = rpt_evict_reg;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twma_pkg::ST_IDLE;
            head_reg      <= '0;
            len_reg       <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        cutoff_reg    <= cutoff_next;
        stamp_reg     <= stamp_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        evict_reg     <= evict_next;
        rpt_x_reg     <= rpt_x_next;
        rpt_y_reg     <= rpt_y_next;
        rpt_count_reg <= rpt_count_next;
        rpt_evict_reg <= rpt_evict_next;
    end

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        cutoff_next    = cutoff_reg;
        stamp_next     = stamp_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        evict_next     = evict_reg;
        rpt_valid_next = rpt_valid_reg;
        rpt_x_next     = rpt_x_reg;
        rpt_y_next     = rpt_y_reg;
        rpt_count_next = rpt_count_reg;
        rpt_evict_next = rpt_evict_reg;
        mem_wr_en      = 1'b0;
        sample.ready   = (state_reg == twma_pkg::ST_IDLE);

        if (rpt_valid_reg && report.ready)
        begin
            rpt_valid_next = 1'b0;
        end

        unique case (state_reg)
            twma_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    stamp_next  = sample.time_ns;
                    dx_next     = sample.delta_x;
                    dy_next     = sample.delta_y;
                    evict_next  = 1'b0;
                    // cutoff floored at zero
                    cutoff_next = (sample.time_ns < window_ext) ? '0
                                                                : sample.time_ns - window_ext;
                    if (sample.action == twma_pkg::ACT_FRAME)
                    begin
                        state_next = twma_pkg::ST_PURGE;
                    end
                    else if (sample.has_focus)
                    begin
                        state_next = twma_pkg::ST_MOTION;
                    end
                    else
                    begin
                        state_next = twma_pkg::ST_EMIT;
                    end
                end
            end

            // One pop per cycle while the head entry is stale
            twma_pkg::ST_PURGE:
            begin
                if (len_reg != '0 && rd_stamp < cutoff_reg)
                begin
                    acc_x_next = acc_x_reg - to_sum(rd_dx);
                    acc_y_next = acc_y_reg - to_sum(rd_dy);
                    head_next  = head_inc;
                    len_next   = len_reg - 1'b1;
                end
                else
                begin
                    state_next = twma_pkg::ST_EMIT;
                end
            end

            // Evict the head if full, then append at the tail
            twma_pkg::ST_MOTION:
            begin
                mem_wr_en  = 1'b1;
                evict_next = full;
                if (full)
                begin
                    acc_x_next = acc_x_reg - to_sum(rd_dx) + to_sum(dx_reg);
                    acc_y_next = acc_y_reg - to_sum(rd_dy) + to_sum(dy_reg);
                    head_next  = head_inc;
                end
                else
                begin
                    acc_x_next = acc_x_reg + to_sum(dx_reg);
                    acc_y_next = acc_y_reg + to_sum(dy_reg);
                    len_next   = len_reg + 1'b1;
                end
                state_next = twma_pkg::ST_EMIT;
            end

            // Load the result register once it is free
            twma_pkg::ST_EMIT:
            begin
                if (!rpt_valid_reg || report.ready)
                begin
                    rpt_valid_next = 1'b1;
                    rpt_x_next     = acc_x_reg;
                    rpt_y_next     = acc_y_reg;
                    rpt_count_next = len_reg;
                    rpt_evict_next = evict_reg;
                    state_next     = twma_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = twma_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/time_window_motion_accumulator_core.sv
`timescale 1ns / 1ps

// Time-windowed moving sum of motion deltas. Items are handled one at a time and
// every item returns one result with the x/y sums, the entry count and an eviction
// flag. A motion item with focus is accepted, then does a read-modify-write of the
// ring, then loads the result; a motion item without focus is accepted and then
// loads the result; a frame item is accepted, purges stale entries and then loads
// the result, popping one head entry per cycle through the ring's single read port.
// The result sits in an output register, so the next item is accepted while it waits;
// that item's result load then waits until the register is taken.
// Entries live in one memory (timestamp, dx, dy) with registered read data; its
// contents are undefined after reset and need no clearing pass. The window register
// may be written at any time the block is idle.
module time_window_motion_accumulator_core #(
    parameter int RING_DEPTH = twma_pkg::RING_DEPTH_DEFAULT,
    parameter int DELTA_BITS = twma_pkg::DELTA_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    twma_sample_if.sink     sample,
    twma_report_if.source   report,
    twma_cfg_if.sink        cfg
);

    localparam int ADDR_BITS  = $clog2(RING_DEPTH);
    localparam int COUNT_BITS = $clog2(RING_DEPTH + 1);
    localparam int MEM_WIDTH  = twma_pkg::STAMP_BITS + 2 * DELTA_BITS;

    logic [twma_pkg::WINDOW_BITS-1:0] window_reg, window_next;

    logic                   mem_wr_en;
    logic [ADDR_BITS-1:0]   mem_wr_addr;
    logic [MEM_WIDTH-1:0]   mem_wr_data;
    logic [ADDR_BITS-1:0]   mem_rd_addr;
    logic [MEM_WIDTH-1:0]   mem_rd_data;

    // Window register
    assign cfg.ready   = 1'b1;
    assign window_next = cfg.valid ? cfg.data : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= twma_pkg::WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    twma_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .DELTA_BITS (DELTA_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .window      (window_reg),
        .sample      (sample),
        .report      (report),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    twma_ring_mem #(
        .DEPTH (RING_DEPTH),
        .WIDTH (MEM_WIDTH)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // One item in flight: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("item accepted while another is in flight");

    // Count never exceeds the ring depth
    assert property (@(posedge clk) disable iff (!rst_n)
        report.valid |-> report.entry_count <= COUNT_BITS'(RING_DEPTH))
        else $error("entry count above ring depth");

    // Eviction only happens with a full ring
    assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.evicted_full |-> report.entry_count == COUNT_BITS'(RING_DEPTH))
        else $error("eviction reported with ring not full");

    // Window write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> window_reg == $past(cfg.data))
        else $error("window write lost");

endmodule

// File: tb/sv/twma_window_checker.sv
`timescale 1ns / 1ps

// Watches the sample, report and window channels, predicts every report from the
// accepted items and compares it with what the block returns.
module twma_window_checker
    import twma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    twma_sample_if      sample,
    twma_report_if      report,
    twma_cfg_if         cfg,
    output int unsigned pending_results,
    output int unsigned fail_count
);

    localparam int DEPTH = RING_DEPTH_DEFAULT;

    typedef struct {
        sum_t       sum_x;
        sum_t       sum_y;
        logic [6:0] entry_count;
        logic       evicted_full;
    } window_report_t;

    // Shadow copy of the ring and its running sums
    logic [STAMP_BITS-1:0]         ring_stamp [DEPTH];
    logic signed [15:0]            ring_dx    [DEPTH];
    logic signed [15:0]            ring_dy    [DEPTH];
    logic [5:0]                    oldest_idx;
    logic [6:0]                    held_count;
    sum_t                          run_sum_x;
    sum_t                          run_sum_y;
    logic [WINDOW_BITS-1:0]        window_reg;

    window_report_t                expected_reports [$];
    int unsigned                   errors;

    // Remove the oldest held delta from the ring and the sums
    function automatic void drop_oldest();
        run_sum_x  = run_sum_x - sum_t'(ring_dx[oldest_idx]);
        run_sum_y  = run_sum_y - sum_t'(ring_dy[oldest_idx]);
        oldest_idx = oldest_idx + 6'd1;
        held_count = held_count - 7'd1;
    endfunction

    // Apply one item to the shadow ring and return the report it causes
    function automatic window_report_t advance_window(
        input logic                  act,
        input logic [STAMP_BITS-1:0] stamp,
        input logic signed [15:0]    dx,
        input logic signed [15:0]    dy,
        input logic                  focus
    );
        window_report_t        r;
        logic [STAMP_BITS-1:0] cutoff;
        logic [5:0]            slot;
        r.evicted_full = 1'b0;
        if (act == ACT_FRAME)
        begin
            // cutoff floored at zero
            cutoff = (stamp < STAMP_BITS'(window_reg)) ? '0 : stamp - STAMP_BITS'(window_reg);
            while (held_count != 0 && ring_stamp[oldest_idx] < cutoff)
                drop_oldest();
        end
        else if (focus)
        begin
            if (held_count == DEPTH)
            begin
                drop_oldest();
                r.evicted_full = 1'b1;
            end
            slot             = oldest_idx + held_count[5:0];
            ring_stamp[slot] = stamp;
            ring_dx[slot]    = dx;
            ring_dy[slot]    = dy;
            held_count       = held_count + 7'd1;
            run_sum_x        = run_sum_x + sum_t'(dx);
            run_sum_y        = run_sum_y + sum_t'(dy);
        end
        r.sum_x       = run_sum_x;
        r.sum_y       = run_sum_y;
        r.entry_count = held_count;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_report_t exp_r;
        if (!rst_n)
        begin
            oldest_idx      = '0;
            held_count      = '0;
            run_sum_x       = '0;
            run_sum_y       = '0;
            window_reg      = WINDOW_RESET;
            errors          = 0;
            expected_reports.delete();
            pending_results <= 0;
            fail_count      <= 0;
        end
        else
        begin
            // results first, so a report never matches an item of the same edge
            if (report.valid && report.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display({"%0t: unexpected report, expected none, ",
                              "got sum_x %0d sum_y %0d count %0d"},
                             $time, report.sum_x, report.sum_y, report.entry_count);
                    errors++;
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    check_field("sum_x", int'(exp_r.sum_x), int'(report.sum_x));
                    check_field("sum_y", int'(exp_r.sum_y), int'(report.sum_y));
                    check_field("entry_count", int'(exp_r.entry_count), int'(report.entry_count));
                    check_field("evicted_full", int'(exp_r.evicted_full),
                                int'(report.evicted_full));
                end
            end
            if (cfg.valid && cfg.ready)
                window_reg = cfg.data;
            if (sample.valid && sample.ready)
                expected_reports.push_back(advance_window(sample.action, sample.time_ns,
                                                          sample.delta_x, sample.delta_y,
                                                          sample.has_focus));
            pending_results <= expected_reports.size();
            fail_count      <= errors;
        end
    end

endmodule

// File: tb/sv/time_window_motion_accumulator_core_tb.sv
`timescale 1ns / 1ps

module time_window_motion_accumulator_core_tb;

    import twma_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int PHASE_ITEMS   = 96;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    logic        clk;
    logic        rst_n;
    int unsigned pending_results;
    int unsigned fail_count;
    int unsigned idle_cycles;
    bit          no_gaps;
    bit          no_stalls;

    twma_sample_if sample_ch ();
    twma_report_if report_ch ();
    twma_cfg_if    cfg_ch ();

    time_window_motion_accumulator_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .report (report_ch),
        .cfg    (cfg_ch)
    );

    twma_window_checker window_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample_ch),
        .report          (report_ch),
        .cfg             (cfg_ch),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Present one item after a random gap and hold it until accepted
    task automatic send_sample(
        input logic                  act,
        input logic [STAMP_BITS-1:0] stamp,
        input logic signed [15:0]    dx,
        input logic signed [15:0]    dy,
        input logic                  focus
    );
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 31) == 0)
            no_gaps = !no_gaps;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.action    <= act;
        sample_ch.time_ns   <= stamp;
        sample_ch.delta_x   <= dx;
        sample_ch.delta_y   <= dy;
        sample_ch.has_focus <= focus;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic write_window(input logic [WINDOW_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop sending and wait for the block to drain
    task automatic settle(input int unsigned extra);
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (extra) @(posedge clk);
    endtask

    // Deltas lean on the extremes
    function automatic logic signed [15:0] pick_delta();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Result side: random stalls per item, with stretches of none
    initial
    begin
        int unsigned stall;
        report_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = no_stalls ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 31) == 0)
                no_stalls = !no_stalls;
            if (stall != 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge clk); while (!report_ch.valid);
        end
    end

    // Watchdog on cycles without any handshake on the sample, report or window channel
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (report_ch.valid && report_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned             phase;
        int unsigned             counted;
        int unsigned             roll;
        int unsigned             step_max;
        bit                      flood;
        logic [WINDOW_BITS-1:0]  window;
        logic [STAMP_BITS-1:0]   clock_ns;
        logic [STAMP_BITS-1:0]   stamp;
        logic                    act;
        logic                    focus;
        logic signed [15:0]      dx;
        logic signed [15:0]      dy;

        rst_n               <= 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.action    <= ACT_FRAME;
        sample_ch.time_ns   <= '0;
        sample_ch.delta_x   <= '0;
        sample_ch.delta_y   <= '0;
        sample_ch.has_focus <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_window(WINDOW_RESET);

        // Directed: empty ring, no focus, field extremes, floored cutoff,
        // purge stopping at an entry that is not old enough
        send_sample(ACT_FRAME,  64'd0,   16'sh0000, 16'sh0000, 1'b1);
        send_sample(ACT_MOTION, 64'd1,   16'sh7FFF, 16'sh8000, 1'b0);
        send_sample(ACT_MOTION, 64'd100, 16'sh7FFF, 16'sh8000, 1'b1);
        send_sample(ACT_MOTION, 64'd5,   16'sh8000, 16'sh7FFF, 1'b1);
        send_sample(ACT_MOTION, 64'd200, -16'sd1,   16'sd1,    1'b1);
        send_sample(ACT_FRAME,  64'd10_000_050, 16'sh0000, 16'sh0000, 1'b0);
        send_sample(ACT_FRAME,  64'd10_000_101, 16'sh7FFF, 16'sh8000, 1'b1);
        send_sample(ACT_FRAME,  64'd9_999_999,  16'sh0000, 16'sh0000, 1'b0);
        send_sample(ACT_MOTION, STAMP_MAX, 16'sh0000, 16'sh0000, 1'b1);
        send_sample(ACT_MOTION, STAMP_MAX, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(ACT_FRAME,  STAMP_MAX, 16'sh0000, 16'sh0000, 1'b1);
        send_sample(ACT_FRAME,  64'd0,     16'sh0000, 16'sh0000, 1'b0);

        // Random phases: even phases mixed traffic, odd phases motion floods
        phase    = 0;
        counted  = 0;
        clock_ns = '0;
        while (counted < RANDOM_ITEMS)
        begin
            settle(SETTLE_CYCLES);
            case (phase % 6)
                0:       window = WINDOW_RESET;
                2:       window = '0;
                3:       window = $urandom;
                4:       window = 32'd1000;
                default: window = '1;
            endcase
            write_window(window);
            flood    = phase[0];
            step_max = ((window >> 3) < 8) ? 8 : (window >> 3);
            case ($urandom_range(0, 2))
                0:       clock_ns = clock_ns;
                1:       clock_ns = 64'($urandom_range(0, 1000));
                default: clock_ns = {$urandom, $urandom};
            endcase

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (flood)
                    clock_ns = clock_ns + 64'($urandom_range(0, 3));
                else
                    clock_ns = clock_ns + 64'($urandom_range(0, step_max));
                stamp    = clock_ns;
                dx       = pick_delta();
                dy       = pick_delta();
                focus    = 1'b1;
                act      = ACT_MOTION;
                if (roll < 8)
                begin
                    // noise: any field value at all
                    act   = logic'($urandom);
                    stamp = {$urandom, $urandom};
                    dx    = 16'($urandom);
                    dy    = 16'($urandom);
                    focus = logic'($urandom);
                end
                else if (roll < (flood ? 10 : 30))
                    act = ACT_FRAME;
                else if (roll < (flood ? 12 : 34))
                    focus = 1'b0;
                else if ($urandom_range(0, 19) == 0)
                    stamp = clock_ns - 64'($urandom_range(0, step_max * 4));
                counted++;
                send_sample(act, stamp, dx, dy, focus);
            end
            phase++;
        end

        settle(DRAIN_CYCLES);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
